// ===== rtl/slpm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted line prefix matcher package
// Shared types, constants and helper functions for the matcher modules.
// ---------------------------------------------------------------------------
package slpm_pkg;

   localparam int KEY_BYTES_DEF = 32;
   localparam int KEY_WORDS = 4;
   localparam int KEY_REG_BYTES = KEY_WORDS * 8;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   typedef enum logic [2:0] {
      CSR_KEY_WORD_0  = 3'd0,
      CSR_KEY_WORD_1  = 3'd1,
      CSR_KEY_WORD_2  = 3'd2,
      CSR_KEY_WORD_3  = 3'd3,
      CSR_KEY_LENGTH  = 3'd4,
      CSR_ALNUM_ONLY  = 3'd5,
      CSR_IGNORE_CASE = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_BELOW      = 2'd0,
      VERDICT_MATCH      = 2'd1,
      VERDICT_PAST       = 2'd2,
      VERDICT_AFTER_STOP = 2'd3
   } verdict_type;

   // One classified byte as it travels from the front to the back.
   typedef struct packed {
      logic       newline;
      logic       keep;
      logic       last;
      logic [7:0] folded;
   } item_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
      logic [7:0] r;
      r = b;
      if (fold_en && b >= 8'd65 && b <= 8'd90) begin
         r = b + 8'd32;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/slpm_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Matcher front end
// Accepts bytes, applies the character filter and case fold, and pushes
// the classified byte into the queue.
// ---------------------------------------------------------------------------
module slpm_front import slpm_pkg::*; (
   input  wire logic       req_valid,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_list,
   input  wire logic       alnum_only,
   input  wire logic       ignore_case,
   input  wire logic       queue_full,
   output logic            req_stall,
   output logic            push,
   output item_type        push_item
);

   logic is_digit;
   logic is_upper;
   logic is_lower;
   logic is_blank;

   always_comb begin
      is_digit = (req_data_byte >= 8'd48) && (req_data_byte <= 8'd57);
      is_upper = (req_data_byte >= 8'd65) && (req_data_byte <= 8'd90);
      is_lower = (req_data_byte >= 8'd97) && (req_data_byte <= 8'd122);
      is_blank = (req_data_byte == 8'd32) || (req_data_byte == 8'd9);

      push_item.newline = (req_data_byte == NEWLINE_BYTE);
      push_item.keep    = !alnum_only || is_digit || is_upper || is_lower || is_blank;
      push_item.last    = req_end_of_list;
      push_item.folded  = fold_byte(req_data_byte, ignore_case);

      req_stall = queue_full;
      push      = req_valid && !queue_full;
   end

endmodule
`default_nettype wire

// ===== rtl/slpm_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Matcher item queue
// Small flip-flop queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module slpm_queue import slpm_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  item_type  push_item,
   input  wire logic pop,
   output logic      full,
   output logic      not_empty,
   output item_type  head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      not_empty = (count_ff != '0);
      head_item = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/slpm_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Matcher back end
// Compares classified bytes against the key, tracks the search phase and
// holds the result register.
// ---------------------------------------------------------------------------
module slpm_back import slpm_pkg::*; #(
   parameter int KEY_BYTES = KEY_BYTES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        item_valid,
   input  item_type                         item,
   output logic                             pop,
   input  wire logic [KEY_REG_BYTES*8-1:0]  key_vec,
   input  wire logic [5:0]                  key_length,
   input  wire logic                        ignore_case,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [1:0]                       rsp_verdict,
   output logic                             rsp_final_line,
   output logic                             rsp_any_match
);

   localparam int KEY_LIMIT = (KEY_BYTES > 63) ? 63 : KEY_BYTES;

   typedef enum logic [1:0] {
      DEC_EQUAL = 2'd0,
      DEC_BELOW = 2'd1,
      DEC_ABOVE = 2'd2
   } decision_type;

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_RUN    = 2'd1,
      PH_STOP   = 2'd2
   } phase_type;

   logic [5:0]   key_pos_ff, key_pos_in;
   decision_type dec_ff, dec_in;
   phase_type    phase_ff, phase_in;
   logic         matched_ff, matched_in;
   logic         out_valid_ff, out_valid_in;
   verdict_type  out_verdict_ff, out_verdict_in;
   logic         out_final_ff, out_final_in;
   logic         out_any_ff, out_any_in;

   logic [5:0]   klen;
   logic [7:0]   key_raw;
   logic [7:0]   key_cmp;
   logic         emit;
   decision_type dec_w;
   logic [5:0]   pos_w;
   logic         is_match;

   always_comb begin
      klen = (int'(key_length) > KEY_LIMIT) ? 6'(KEY_LIMIT) : key_length;
      if (int'(key_pos_ff) < KEY_REG_BYTES) begin
         key_raw = key_vec[{key_pos_ff[4:0], 3'b000} +: 8];
      end else begin
         key_raw = 8'd0;
      end
      key_cmp = fold_byte(key_raw, ignore_case);

      pop = item_valid && (!out_valid_ff || !rsp_stall);

      key_pos_in     = key_pos_ff;
      dec_in         = dec_ff;
      phase_in       = phase_ff;
      matched_in     = matched_ff;
      out_verdict_in = out_verdict_ff;
      out_final_in   = out_final_ff;
      out_any_in     = out_any_ff;
      emit           = 1'b0;
      dec_w          = dec_ff;
      pos_w          = key_pos_ff;
      is_match       = 1'b0;

      if (pop) begin
         if (!item.newline && dec_ff == DEC_EQUAL && key_pos_ff < klen && item.keep) begin
            if (item.folded < key_cmp) begin
               dec_w = DEC_BELOW;
            end else if (item.folded > key_cmp) begin
               dec_w = DEC_ABOVE;
            end else begin
               pos_w = key_pos_ff + 6'd1;
            end
         end

         if (item.newline || item.last) begin
            emit = 1'b1;
            if (dec_w == DEC_EQUAL && pos_w < klen) begin
               dec_w = DEC_BELOW;
            end
            is_match = (dec_w == DEC_EQUAL);
            out_any_in = matched_ff;
            case (phase_ff)
               PH_SEARCH, PH_RUN: begin
                  if (is_match) begin
                     out_verdict_in = VERDICT_MATCH;
                     phase_in       = PH_RUN;
                     matched_in     = 1'b1;
                     out_any_in     = 1'b1;
                  end else if (phase_ff == PH_SEARCH && dec_w == DEC_BELOW) begin
                     out_verdict_in = VERDICT_BELOW;
                  end else begin
                     out_verdict_in = VERDICT_PAST;
                     phase_in       = PH_STOP;
                  end
               end
               default: begin
                  out_verdict_in = VERDICT_AFTER_STOP;
                  phase_in       = PH_STOP;
               end
            endcase
            out_final_in = item.last;
            key_pos_in   = 6'd0;
            dec_in       = DEC_EQUAL;
            if (item.last) begin
               phase_in   = PH_SEARCH;
               matched_in = 1'b0;
            end
         end else begin
            key_pos_in = pos_w;
            dec_in     = dec_w;
         end
      end

      out_valid_in = emit || (out_valid_ff && rsp_stall);

      rsp_valid      = out_valid_ff;
      rsp_verdict    = out_verdict_ff;
      rsp_final_line = out_final_ff;
      rsp_any_match  = out_any_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff   <= '0;
         dec_ff       <= DEC_EQUAL;
         phase_ff     <= PH_SEARCH;
         matched_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         key_pos_ff   <= key_pos_in;
         dec_ff       <= dec_in;
         phase_ff     <= phase_in;
         matched_ff   <= matched_in;
         out_valid_ff <= out_valid_in;
      end
      out_verdict_ff <= out_verdict_in;
      out_final_ff   <= out_final_in;
      out_any_ff     <= out_any_in;
   end

endmodule
`default_nettype wire

// ===== rtl/sorted_line_prefix_matcher_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted line prefix matcher, top level
// Scans a sorted line list byte by byte and gives one verdict per line.
// ---------------------------------------------------------------------------
// The byte that closes a line (newline or final byte) passes through the queue,
// and the verdict for that line is then presented from the result register of
// the back end; it transfers when the result side is not stalled.
// Throughput: one byte per cycle while the result side does not stall, bounded
// by the single key-byte compare in the back end that each byte needs.
// Reset is synchronous and active high; it clears the registers to zero, the
// queue, the line state, the search phase and the valid flag of the result register.
// ---------------------------------------------------------------------------
module sorted_line_prefix_matcher_top import slpm_pkg::*; #(
   parameter int KEY_BYTES   = KEY_BYTES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Byte stream.
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_end_of_list,
   // Verdicts.
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_verdict,
   output logic                       rsp_final_line,
   output logic                       rsp_any_match,
   // Register port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // Registers. Each sits at an 8-byte aligned address, so the register
   // index is the address bits above the byte offset within a word.
   logic [63:0] key_word_ff [KEY_WORDS];
   logic [5:0]  key_length_ff;
   logic        alnum_only_ff;
   logic        ignore_case_ff;

   logic          csr_write;
   csr_index_type csr_index;
   logic [KEY_REG_BYTES*8-1:0] key_vec;

   // Front to queue and queue to back.
   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     queue_not_empty;
   item_type head_item;
   logic     pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[5:3]);

   always_comb begin
      for (int i = 0; i < KEY_WORDS; i++) begin
         key_vec[i*64 +: 64] = key_word_ff[i];
      end
   end

   // Read data follows the address directly; unknown indexes read as zero.
   always_comb begin
      case (csr_index)
         CSR_KEY_WORD_0:  csr_prdata = key_word_ff[0];
         CSR_KEY_WORD_1:  csr_prdata = key_word_ff[1];
         CSR_KEY_WORD_2:  csr_prdata = key_word_ff[2];
         CSR_KEY_WORD_3:  csr_prdata = key_word_ff[3];
         CSR_KEY_LENGTH:  csr_prdata = {58'd0, key_length_ff};
         CSR_ALNUM_ONLY:  csr_prdata = {63'd0, alnum_only_ff};
         CSR_IGNORE_CASE: csr_prdata = {63'd0, ignore_case_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_word_ff[i] <= '0;
         end
         key_length_ff  <= '0;
         alnum_only_ff  <= 1'b0;
         ignore_case_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_KEY_WORD_0:  key_word_ff[0] <= csr_pwdata;
            CSR_KEY_WORD_1:  key_word_ff[1] <= csr_pwdata;
            CSR_KEY_WORD_2:  key_word_ff[2] <= csr_pwdata;
            CSR_KEY_WORD_3:  key_word_ff[3] <= csr_pwdata;
            CSR_KEY_LENGTH:  key_length_ff  <= csr_pwdata[5:0];
            CSR_ALNUM_ONLY:  alnum_only_ff  <= csr_pwdata[0];
            CSR_IGNORE_CASE: ignore_case_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // The front end classifies each byte in the cycle of its transfer and
   // stalls the stream only when the queue is full.
   slpm_front u_front (
      .req_valid       (req_valid),
      .req_data_byte   (req_data_byte),
      .req_end_of_list (req_end_of_list),
      .alnum_only      (alnum_only_ff),
      .ignore_case     (ignore_case_ff),
      .queue_full      (queue_full),
      .req_stall       (req_stall),
      .push            (push),
      .push_item       (push_item)
   );

   // The queue lets the byte stream keep flowing while a verdict waits.
   slpm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   // The back end holds the per-line compare state and the search phase,
   // and registers each verdict for the result side.
   slpm_back #(
      .KEY_BYTES (KEY_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (queue_not_empty),
      .item           (head_item),
      .pop            (pop),
      .key_vec        (key_vec),
      .key_length     (key_length_ff),
      .ignore_case    (ignore_case_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_verdict    (rsp_verdict),
      .rsp_final_line (rsp_final_line),
      .rsp_any_match  (rsp_any_match)
   );

   // A matching line always reports that some line has matched.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == VERDICT_MATCH) |-> rsp_any_match)
      else $error("match verdict without any_match");

   // A line below the key is only skipped while still searching, before
   // any line of the list has matched.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == VERDICT_BELOW) |-> !rsp_any_match)
      else $error("below verdict after a match");

   // The queue is never popped while it is empty.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_not_empty)
      else $error("queue popped while empty");

   // A key length write lands in its register.
   assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_index == CSR_KEY_LENGTH) |=> key_length_ff == $past(csr_pwdata[5:0]))
      else $error("key length write lost");

endmodule
`default_nettype wire
